[sv/dbd_pkg.sv]
`timescale 1ns / 1ps
// dbd_pkg: shared widths, constants, month table and controller/datapath
// command and status types for the days-between-dates core. No dependencies.
package dbd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;

  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
  localparam int DAYS_COMMON = 365;

  // mod counters for the leap rule
  localparam int MOD100_W = 7;
  localparam int MOD400_W = 9;
  localparam logic [MOD100_W-1:0] MOD100_LAST = MOD100_W'(99);
  localparam logic [MOD400_W-1:0] MOD400_LAST = MOD400_W'(399);

  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic load;       // capture an item, clear the sweep
    logic step;       // process one year
    logic calc_num;   // form both day numbers
    logic store_out;  // write |difference| to the output register
  } dbd_cmd_t;

  typedef struct packed {
    logic sweep_done; // current year is the last one needed
  } dbd_sts_t;

  // days in the months before month m in a common year; past December = 365
  function automatic count_t days_before_month(input month_t m);
    count_t d;
    case (m)
      4'd0, 4'd1: d = COUNT_W'(0);
      4'd2:       d = COUNT_W'(31);
      4'd3:       d = COUNT_W'(59);
      4'd4:       d = COUNT_W'(90);
      4'd5:       d = COUNT_W'(120);
      4'd6:       d = COUNT_W'(151);
      4'd7:       d = COUNT_W'(181);
      4'd8:       d = COUNT_W'(212);
      4'd9:       d = COUNT_W'(243);
      4'd10:      d = COUNT_W'(273);
      4'd11:      d = COUNT_W'(304);
      4'd12:      d = COUNT_W'(334);
      default:    d = COUNT_W'(DAYS_COMMON);
    endcase
    return d;
  endfunction

endpackage

[sv/dbd_datapath.sv]
`timescale 1ns / 1ps
// dbd_datapath: year sweep accumulators, leap counters, day numbers and
// the output register. Uses dbd_pkg; driven by dbd_ctrl commands.
module dbd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  dbd_pkg::dbd_cmd_t cmd,
  output dbd_pkg::dbd_sts_t sts,
  input  dbd_pkg::year_t    in_first_year,
  input  dbd_pkg::month_t   in_first_month,
  input  dbd_pkg::day_t     in_first_day,
  input  dbd_pkg::year_t    in_second_year,
  input  dbd_pkg::month_t   in_second_month,
  input  dbd_pkg::day_t     in_second_day,
  output dbd_pkg::count_t   out_day_count
);
  import dbd_pkg::*;

  year_t  ya_r, yb_r, ymax_r, y_r;
  month_t ma_r, mb_r;
  day_t   da_r, db_r;
  logic [1:0]          mod4_r;
  logic [MOD100_W-1:0] mod100_r;
  logic [MOD400_W-1:0] mod400_r;
  count_t acc_a_r, acc_b_r, na_r, nb_r, out_r;
  logic   leap_a_r, leap_b_r;

  year_t  ya_sat, yb_sat;
  logic   leap;
  count_t year_len, na_nxt, nb_nxt, diff;

  assign ya_sat = (in_first_year  > YEAR_MAX) ? YEAR_MAX : in_first_year;
  assign yb_sat = (in_second_year > YEAR_MAX) ? YEAR_MAX : in_second_year;

  assign leap     = ((mod4_r == 2'd0) && (mod100_r != '0)) || (mod400_r == '0);
  assign year_len = COUNT_W'(DAYS_COMMON) + COUNT_W'(leap);

  assign na_nxt = acc_a_r + days_before_month(ma_r) + COUNT_W'(da_r)
                + COUNT_W'((ma_r > MONTH_FEB) && leap_a_r);
  assign nb_nxt = acc_b_r + days_before_month(mb_r) + COUNT_W'(db_r)
                + COUNT_W'((mb_r > MONTH_FEB) && leap_b_r);

  assign diff = (na_r > nb_r) ? (na_r - nb_r) : (nb_r - na_r);

  assign sts.sweep_done = (y_r == ymax_r);
  assign out_day_count  = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ya_r     <= ya_sat;
      yb_r     <= yb_sat;
      ymax_r   <= (ya_sat > yb_sat) ? ya_sat : yb_sat;
      ma_r     <= in_first_month;
      mb_r     <= in_second_month;
      da_r     <= in_first_day;
      db_r     <= in_second_day;
      y_r      <= '0;
      mod4_r   <= '0;
      mod100_r <= '0;
      mod400_r <= '0;
      acc_a_r  <= '0;
      acc_b_r  <= '0;
      leap_a_r <= 1'b0;
      leap_b_r <= 1'b0;
    end else if (cmd.step) begin
      if (y_r < ya_r) acc_a_r <= acc_a_r + year_len;
      if (y_r < yb_r) acc_b_r <= acc_b_r + year_len;
      if (y_r == ya_r) leap_a_r <= leap;
      if (y_r == yb_r) leap_b_r <= leap;
      y_r      <= y_r + YEAR_W'(1);
      mod4_r   <= mod4_r + 2'd1;
      mod100_r <= (mod100_r == MOD100_LAST) ? '0 : mod100_r + MOD100_W'(1);
      mod400_r <= (mod400_r == MOD400_LAST) ? '0 : mod400_r + MOD400_W'(1);
    end
    if (cmd.calc_num) begin
      na_r <= na_nxt;
      nb_r <= nb_nxt;
    end
    if (cmd.store_out) out_r <= diff;
  end

`ifndef NO_ASSERTIONS
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (y_r <= ymax_r))
    else $error("year sweep ran past the last year");

  a_mod4_track: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (mod4_r == y_r[1:0]))
    else $error("mod-4 counter out of step with year");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> ((y_r == '0) && (acc_a_r == '0) && (acc_b_r == '0)))
    else $error("sweep not cleared on load");
`endif

endmodule

[sv/dbd_ctrl.sv]
`timescale 1ns / 1ps
// dbd_ctrl: state machine sequencing load, year sweep, day numbers and
// output handoff. Uses dbd_pkg command/status types.
module dbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dbd_pkg::dbd_cmd_t cmd,
  input  dbd_pkg::dbd_sts_t sts
);
  import dbd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_NUMS  = 2'd2;
  localparam logic [1:0] S_DIFF  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // output register can take a new result this cycle
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.sweep_done) state_nxt = S_NUMS;
      end
      S_NUMS: begin
        cmd.calc_num = 1'b1;
        state_nxt    = S_DIFF;
      end
      S_DIFF: begin
        if (out_free) begin
          cmd.store_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SWEEP) && sts.sweep_done) |=> (state_r == S_NUMS))
    else $error("sweep did not end on last year");

  a_out_from_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_DIFF))
    else $error("result raised outside the difference step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_out |-> out_free)
    else $error("output register overwritten while held");
`endif

endmodule

[sv/days_between_dates_core.sv]
`timescale 1ns / 1ps
// The year sweep runs from year 0 to the later input year, clamped to 9999, handling
// one year per cycle; then the day numbers and their difference are registered. A new
// item is taken only once the last result is stored; in_ready is high while the sweep
// is idle, even with a result still waiting in the output register.
// Reset: rst_n synchronous, active low; clears the state machine and out_valid.
module days_between_dates_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dbd_pkg::year_t   in_first_year,
  input  dbd_pkg::month_t  in_first_month,
  input  dbd_pkg::day_t    in_first_day,
  input  dbd_pkg::year_t   in_second_year,
  input  dbd_pkg::month_t  in_second_month,
  input  dbd_pkg::day_t    in_second_day,
  output logic             out_valid,
  input  logic             out_ready,
  output dbd_pkg::count_t  out_day_count
);
  import dbd_pkg::*;

  dbd_cmd_t cmd;
  dbd_sts_t sts;

  dbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dbd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_first_year   (in_first_year),
    .in_first_month  (in_first_month),
    .in_first_day    (in_first_day),
    .in_second_year  (in_second_year),
    .in_second_month (in_second_month),
    .in_second_day   (in_second_day),
    .out_day_count   (out_day_count)
  );

endmodule
